// ===== rtl/bcgl_pkg.sv =====
// ----------------------------------------------------------------------------
// bcgl_pkg: shared widths, codes and types for the byte class grid layout
// Field widths, register indexes, class codes, the divider request and
// response words and the result word that leaves the layout core.
// ----------------------------------------------------------------------------
package bcgl_pkg;

   localparam int AREA_BITS   = 12;
   localparam int BLOCK_BITS  = 24;
   localparam int CELL_BITS   = 12;
   localparam int X_BITS      = 13;
   localparam int Y_BITS      = 16;
   localparam int H_BITS      = 13;
   localparam int CLASS_BITS  = 4;
   localparam int BYTE_BITS   = 8;
   localparam int DIV_BITS    = 25;
   localparam int PROD_BITS   = 24;
   localparam int IDX_BITS    = 2;
   localparam int WDATA_BITS  = 24;

   localparam int COORD_BITS_DEFAULT = 12;

   // configuration register indexes
   localparam logic [IDX_BITS-1:0] REG_AREA_WIDTH  = 2'd0;
   localparam logic [IDX_BITS-1:0] REG_AREA_HEIGHT = 2'd1;
   localparam logic [IDX_BITS-1:0] REG_BLOCK_SIZE  = 2'd2;

   localparam logic [AREA_BITS-1:0]  AREA_WIDTH_RST  = 12'd256;
   localparam logic [AREA_BITS-1:0]  AREA_HEIGHT_RST = 12'd512;
   localparam logic [BLOCK_BITS-1:0] BLOCK_SIZE_RST  = 24'd4096;

   // op codes
   localparam logic OP_START = 1'b0;
   localparam logic OP_BYTE  = 1'b1;

   // byte classes
   localparam logic [CLASS_BITS-1:0] CLS_NUL    = 4'd0;
   localparam logic [CLASS_BITS-1:0] CLS_SPACE  = 4'd1;
   localparam logic [CLASS_BITS-1:0] CLS_CTRL   = 4'd2;
   localparam logic [CLASS_BITS-1:0] CLS_CRLF   = 4'd3;
   localparam logic [CLASS_BITS-1:0] CLS_DIGIT  = 4'd4;
   localparam logic [CLASS_BITS-1:0] CLS_LETTER = 4'd5;
   localparam logic [CLASS_BITS-1:0] CLS_PUNCT  = 4'd6;
   localparam logic [CLASS_BITS-1:0] CLS_DEL    = 4'd7;
   localparam logic [CLASS_BITS-1:0] CLS_HIGH   = 4'd8;

   typedef struct packed {
      logic [AREA_BITS-1:0]  area_width;
      logic [AREA_BITS-1:0]  area_height;
      logic [BLOCK_BITS-1:0] block_size;
   } cfg_type;

   typedef struct packed {
      logic                  op;
      logic [BYTE_BITS-1:0]  byte_value;
   } item_type;

   typedef struct packed {
      logic [X_BITS-1:0]     rect_x;
      logic [Y_BITS-1:0]     rect_y;
      logic [CELL_BITS-1:0]  rect_width;
      logic [H_BITS-1:0]     rect_height;
      logic [CLASS_BITS-1:0] byte_class;
   } result_type;

   typedef struct packed {
      logic                  start;
      logic [DIV_BITS-1:0]   dividend;
      logic [CELL_BITS-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [DIV_BITS-1:0]   quotient;
      logic [CELL_BITS-1:0]  remainder;
   } div_rsp_type;

endpackage

// ===== rtl/bcgl_if.sv =====
// ----------------------------------------------------------------------------
// bcgl_if: channel interfaces of the byte class grid layout
// Request, response and register write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bcgl_req_if;
   logic                            valid;
   logic                            ready;
   logic                            op;
   logic [bcgl_pkg::BYTE_BITS-1:0]  byte_value;

   modport source (output valid, output op, output byte_value, input ready);
   modport sink   (input valid, input op, input byte_value, output ready);
endinterface

interface bcgl_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [bcgl_pkg::X_BITS-1:0]      rect_x;
   logic [bcgl_pkg::Y_BITS-1:0]      rect_y;
   logic [bcgl_pkg::CELL_BITS-1:0]   rect_width;
   logic [bcgl_pkg::H_BITS-1:0]      rect_height;
   logic [bcgl_pkg::CLASS_BITS-1:0]  byte_class;

   modport source (output valid, output rect_x, output rect_y, output rect_width,
                   output rect_height, output byte_class, input ready);
   modport sink   (input valid, input rect_x, input rect_y, input rect_width,
                   input rect_height, input byte_class, output ready);
endinterface

interface bcgl_csr_if;
   logic                             valid;
   logic                             ready;
   logic [bcgl_pkg::IDX_BITS-1:0]    reg_index;
   logic [bcgl_pkg::WDATA_BITS-1:0]  wdata;

   modport source (output valid, output reg_index, output wdata, input ready);
   modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// ===== rtl/bcgl_div.sv =====
// ----------------------------------------------------------------------------
// bcgl_div: shared restoring divider
// One quotient bit per cycle; done pulses as the last bit is registered.
// ----------------------------------------------------------------------------
module bcgl_div (
   input  logic                  clock,
   input  logic                  reset,
   input  bcgl_pkg::div_req_type div_req,
   output bcgl_pkg::div_rsp_type div_rsp
);

   localparam int DivBits   = bcgl_pkg::DIV_BITS;
   localparam int CellBits  = bcgl_pkg::CELL_BITS;
   localparam int CntBits   = $clog2(DivBits);
   localparam int LastInt   = DivBits - 1;
   localparam logic [CntBits-1:0] LastCount = LastInt[CntBits-1:0];

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CntBits-1:0]  cnt_ff, cnt_in;
   logic [DivBits-1:0]  quo_ff, quo_in;
   logic [CellBits-1:0] dsr_ff, dsr_in;
   logic [CellBits-1:0] rem_ff, rem_in;

   logic [CellBits:0]   rem_sh;
   logic [CellBits:0]   rem_sub;
   logic                fits;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[DivBits-1]};
      fits    = rem_sh >= {1'b0, dsr_ff};
      rem_sub = rem_sh - {1'b0, dsr_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;

      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = div_req.dividend;
         dsr_in  = div_req.divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         // quotient bits shift in where the dividend shifts out
         quo_in = {quo_ff[DivBits-2:0], fits};
         rem_in = fits ? rem_sub[CellBits-1:0] : rem_sh[CellBits-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LastCount) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

// ===== rtl/bcgl_core.sv =====
// ----------------------------------------------------------------------------
// bcgl_core: layout sequencer and grid position state
// Start words run the cell size search over the shared divider and a
// 12x12 multiplier; byte words are placed without leaving the idle state.
// ----------------------------------------------------------------------------
module bcgl_core #(
   parameter int COORD_BITS = bcgl_pkg::COORD_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bcgl_pkg::cfg_type     cfg,
   input  logic                  take,
   input  bcgl_pkg::item_type    item,
   output logic                  idle,
   output bcgl_pkg::result_type  result
);

   localparam int CellBits = bcgl_pkg::CELL_BITS;
   localparam int XBits    = bcgl_pkg::X_BITS;
   localparam int YBits    = bcgl_pkg::Y_BITS;
   localparam int HBits    = bcgl_pkg::H_BITS;
   localparam int DivBits  = bcgl_pkg::DIV_BITS;
   localparam int ProdBits = bcgl_pkg::PROD_BITS;
   localparam int BlkBits  = bcgl_pkg::BLOCK_BITS;
   localparam int CapBits  = (COORD_BITS < CellBits) ? COORD_BITS : CellBits;
   localparam int CmaxInt  = (1 << CapBits) - 1;
   localparam logic [CellBits-1:0] Cmax = CmaxInt[CellBits-1:0];

   typedef enum logic [13:0] {
      ST_IDLE     = 14'b00000000000001,
      ST_INIT     = 14'b00000000000010,
      ST_PR_GO    = 14'b00000000000100,
      ST_PR_WAIT  = 14'b00000000001000,
      ST_CHK      = 14'b00000000010000,
      ST_RC_GO    = 14'b00000000100000,
      ST_RC_WAIT  = 14'b00000001000000,
      ST_CMP      = 14'b00000010000000,
      ST_FRC_GO   = 14'b00000100000000,
      ST_FRC_WAIT = 14'b00001000000000,
      ST_USED     = 14'b00010000000000,
      ST_SL_GO    = 14'b00100000000000,
      ST_SL_WAIT  = 14'b01000000000000,
      ST_FIN      = 14'b10000000000000
   } state_type;

   function automatic logic [bcgl_pkg::CLASS_BITS-1:0] classify(
      input logic [bcgl_pkg::BYTE_BITS-1:0] b);
      logic [bcgl_pkg::CLASS_BITS-1:0] c;
      if (b == 8'h00)                                   c = bcgl_pkg::CLS_NUL;
      else if (b == 8'h20 || b == 8'h09)                c = bcgl_pkg::CLS_SPACE;
      else if (b == 8'h0A || b == 8'h0D)                c = bcgl_pkg::CLS_CRLF;
      else if (b < 8'h20)                               c = bcgl_pkg::CLS_CTRL;
      else if (b >= 8'h30 && b <= 8'h39)                c = bcgl_pkg::CLS_DIGIT;
      else if ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
               b == 8'h5F)                              c = bcgl_pkg::CLS_LETTER;
      else if (b == 8'h7F)                              c = bcgl_pkg::CLS_DEL;
      else if (b >= 8'h80)                              c = bcgl_pkg::CLS_HIGH;
      else                                              c = bcgl_pkg::CLS_PUNCT;
      return c;
   endfunction

   state_type            state_ff, state_in;
   // cells grow as squares in the search, so one register holds the cell size
   logic [CellBits-1:0]  cell_ff, cell_in;
   logic [CellBits-1:0]  cpr_ff, cpr_in;
   logic [CellBits-1:0]  slack_ff, slack_in;
   logic [HBits-1:0]     step_ff, step_in;
   logic [CellBits-1:0]  col_ff, col_in;
   logic [XBits-1:0]     xoff_ff, xoff_in;
   logic [YBits-1:0]     ypos_ff, ypos_in;
   logic [HBits-1:0]     rowh_ff, rowh_in;
   logic                 grow_ok_ff, grow_ok_in;
   logic                 init_ph_ff, init_ph_in;

   logic [CellBits-1:0]  cand_ff, cand_in;
   logic [CellBits-1:0]  ntrial_ff, ntrial_in;
   logic [DivBits-1:0]   rows_ff, rows_in;
   logic [ProdBits-1:0]  prod_ff, prod_in;

   logic [CellBits-1:0]  aw_m, ah_m, left12, avail;
   logic [BlkBits-1:0]   bsz_eff;
   logic [CellBits-1:0]  pr_sum, pr_n;
   logic                 q_big;
   logic [CellBits-1:0]  mul_a, mul_b;
   logic [HBits-1:0]     tr_h, tr_step;
   logic [CellBits-1:0]  tr_slack;
   logic [CellBits-1:0]  col_nx;
   logic [YBits:0]       ysum;

   bcgl_pkg::div_req_type div_req;
   bcgl_pkg::div_rsp_type div_rsp;

   bcgl_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      aw_m    = cfg.area_width & Cmax;
      ah_m    = cfg.area_height & Cmax;
      left12  = {1'b0, aw_m[CellBits-1:1]} + 12'd1;
      avail   = (aw_m > left12) ? aw_m - left12 : '0;
      bsz_eff = (cfg.block_size == '0) ? 24'd1 : cfg.block_size;

      // cells per row from avail / width: round up past 4 spare pixels
      pr_sum = div_rsp.quotient[CellBits-1:0] +
               {{(CellBits-1){1'b0}}, (div_rsp.remainder > 12'd4)};
      pr_n   = (pr_sum == '0) ? 12'd1 : pr_sum;
      q_big  = div_rsp.quotient[DivBits-1:CellBits] != '0;

      // taking a row: height with its slack, slack drains and saturates
      tr_h     = {1'b0, cell_ff} + step_ff;
      tr_slack = slack_ff;
      tr_step  = step_ff;
      if (slack_ff != '0)
         tr_slack = ({1'b0, slack_ff} > step_ff) ? slack_ff - step_ff[CellBits-1:0] : '0;
      else
         tr_step = '0;

      col_nx = col_ff + 12'd1;
      ysum   = {1'b0, ypos_ff} + {4'd0, rowh_ff};
   end

   // divider and multiplier operand selection
   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = {13'd0, avail};
      div_req.divisor  = cand_ff;
      mul_a            = avail;
      mul_b            = ah_m;
      case (state_ff)
         ST_PR_GO: begin
            div_req.start = 1'b1;
         end
         ST_RC_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = {1'b0, bsz_eff} + {13'd0, ntrial_ff} - 25'd1;
            div_req.divisor  = ntrial_ff;
         end
         ST_FRC_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = {1'b0, bsz_eff} + {13'd0, cpr_ff} - 25'd1;
            div_req.divisor  = cpr_ff;
         end
         ST_SL_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = {13'd0, slack_ff};
            div_req.divisor  = rows_ff[CellBits-1:0];
         end
         ST_RC_WAIT: begin
            mul_a = div_rsp.quotient[CellBits-1:0];
            mul_b = cand_ff;
         end
         ST_FRC_WAIT: begin
            mul_a = div_rsp.quotient[CellBits-1:0];
            mul_b = cell_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      cell_in    = cell_ff;
      cpr_in     = cpr_ff;
      slack_in   = slack_ff;
      step_in    = step_ff;
      col_in     = col_ff;
      xoff_in    = xoff_ff;
      ypos_in    = ypos_ff;
      rowh_in    = rowh_ff;
      grow_ok_in = grow_ok_ff;
      init_ph_in = init_ph_ff;
      cand_in    = cand_ff;
      ntrial_in  = ntrial_ff;
      rows_in    = rows_ff;
      prod_in    = prod_ff;

      case (state_ff)
         ST_IDLE: begin
            if (take && item.op == bcgl_pkg::OP_START) begin
               state_in = ST_INIT;
            end else if (take) begin
               if (col_nx >= cpr_ff) begin
                  col_in   = '0;
                  xoff_in  = '0;
                  ypos_in  = ysum[YBits] ? {YBits{1'b1}} : ysum[YBits-1:0];
                  rowh_in  = tr_h;
                  slack_in = tr_slack;
                  step_in  = tr_step;
               end else begin
                  col_in  = col_nx;
                  xoff_in = xoff_ff + {1'b0, cell_ff};
               end
            end
         end
         ST_INIT: begin
            cell_in    = 12'd1;
            cand_in    = 12'd1;
            init_ph_in = 1'b1;
            prod_in    = {12'd0, mul_a} * {12'd0, mul_b};
            state_in   = ST_PR_GO;
         end
         ST_PR_GO: begin
            state_in = ST_PR_WAIT;
         end
         ST_PR_WAIT: begin
            if (div_rsp.done) begin
               ntrial_in = pr_n;
               if (init_ph_ff) begin
                  cpr_in     = pr_n;
                  grow_ok_in = cfg.block_size < prod_ff;
                  init_ph_in = 1'b0;
                  state_in   = ST_CHK;
               end else begin
                  state_in = ST_RC_GO;
               end
            end
         end
         ST_CHK: begin
            if (grow_ok_ff && cell_ff < Cmax) begin
               cand_in  = cell_ff + 12'd1;
               state_in = ST_PR_GO;
            end else begin
               state_in = ST_FRC_GO;
            end
         end
         ST_RC_GO: begin
            state_in = ST_RC_WAIT;
         end
         ST_RC_WAIT: begin
            if (div_rsp.done) begin
               // more rows than any area height: cannot fit
               if (q_big) begin
                  state_in = ST_FRC_GO;
               end else begin
                  prod_in  = {12'd0, mul_a} * {12'd0, mul_b};
                  state_in = ST_CMP;
               end
            end
         end
         ST_CMP: begin
            if (prod_ff > {12'd0, ah_m}) begin
               state_in = ST_FRC_GO;
            end else begin
               cell_in  = cand_ff;
               cpr_in   = ntrial_ff;
               state_in = ST_CHK;
            end
         end
         ST_FRC_GO: begin
            state_in = ST_FRC_WAIT;
         end
         ST_FRC_WAIT: begin
            if (div_rsp.done) begin
               rows_in = div_rsp.quotient;
               if (q_big) begin
                  slack_in = '0;
                  state_in = ST_SL_GO;
               end else begin
                  prod_in  = {12'd0, mul_a} * {12'd0, mul_b};
                  state_in = ST_USED;
               end
            end
         end
         ST_USED: begin
            slack_in = (prod_ff < {12'd0, ah_m}) ? ah_m - prod_ff[CellBits-1:0] : '0;
            state_in = ST_SL_GO;
         end
         ST_SL_GO: begin
            state_in = ST_SL_WAIT;
         end
         ST_SL_WAIT: begin
            if (div_rsp.done) begin
               if (rows_ff[DivBits-1:CellBits] != '0)
                  step_in = 13'd1;
               else
                  step_in = {1'b0, div_rsp.quotient[CellBits-1:0]} + 13'd1;
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            col_in   = '0;
            xoff_in  = '0;
            ypos_in  = '0;
            rowh_in  = tr_h;
            slack_in = tr_slack;
            step_in  = tr_step;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cell_ff    <= 12'd1;
         cpr_ff     <= 12'd1;
         slack_ff   <= '0;
         step_ff    <= '0;
         col_ff     <= '0;
         xoff_ff    <= '0;
         ypos_ff    <= '0;
         rowh_ff    <= 13'd1;
         grow_ok_ff <= 1'b0;
         init_ph_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cell_ff    <= cell_in;
         cpr_ff     <= cpr_in;
         slack_ff   <= slack_in;
         step_ff    <= step_in;
         col_ff     <= col_in;
         xoff_ff    <= xoff_in;
         ypos_ff    <= ypos_in;
         rowh_ff    <= rowh_in;
         grow_ok_ff <= grow_ok_in;
         init_ph_ff <= init_ph_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff   <= cand_in;
      ntrial_ff <= ntrial_in;
      rows_ff   <= rows_in;
      prod_ff   <= prod_in;
   end

   assign idle               = state_ff == ST_IDLE;
   assign result.rect_x      = {1'b0, left12} + xoff_ff;
   assign result.rect_y      = ypos_ff;
   assign result.rect_width  = cell_ff;
   assign result.rect_height = rowh_ff;
   assign result.byte_class  = classify(item.byte_value);

   a_cell_nonzero: assert property (@(posedge clock) disable iff (reset)
      cell_ff != '0 && cpr_ff != '0)
      else $error("cell size or cells per row is zero");

   a_col_in_row: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> col_ff < cpr_ff)
      else $error("column index past end of row");

   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      (take && item.op == bcgl_pkg::OP_START) |=> state_ff == ST_INIT)
      else $error("start word did not launch layout");

   a_byte_single: assert property (@(posedge clock) disable iff (reset)
      (take && item.op == bcgl_pkg::OP_BYTE) |=> state_ff == ST_IDLE)
      else $error("byte word left idle");

   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_PR_WAIT || state_ff == ST_RC_WAIT ||
                        state_ff == ST_FRC_WAIT || state_ff == ST_SL_WAIT))
      else $error("divider finished with nobody waiting");

endmodule

// ===== rtl/byte_class_grid_layout.sv =====
// ----------------------------------------------------------------------------
// byte_class_grid_layout: byte class grid layout, top level
// Register file, request handshake and result register around the core.
//
//   channel   dir  payload                                        accepted
//   req_bus   in   op, byte_value                                 valid & ready
//   rsp_bus   out  rect_x, rect_y, rect_width, rect_height,       valid & ready
//                  byte_class
//   csr_bus   in   reg_index, wdata                               valid & ready
//
// A byte word is taken while the core is idle; its result sits in an output
// register, and the next word is taken in the same cycle as that result is drained.
// A start word runs the cell size search; no word is taken until it ends, and
// each trial cell size takes two divisions in the shared divider.
// csr_bus is always ready; writes are expected only when the block is idle.
// Synchronous reset restores register defaults and a one-pixel grid.
// ----------------------------------------------------------------------------
module byte_class_grid_layout #(
   parameter int COORD_BITS = bcgl_pkg::COORD_BITS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   bcgl_req_if.sink     req_bus,
   bcgl_rsp_if.source   rsp_bus,
   bcgl_csr_if.sink     csr_bus
);

   bcgl_pkg::cfg_type    cfg_ff, cfg_in;
   bcgl_pkg::item_type   item;
   bcgl_pkg::result_type result;
   bcgl_pkg::result_type rsp_data_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 core_idle;
   logic                 take;

   assign item.op         = req_bus.op;
   assign item.byte_value = req_bus.byte_value;

   assign req_bus.ready = core_idle && (!rsp_valid_ff || rsp_bus.ready);
   assign take          = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   bcgl_core #(
      .COORD_BITS (COORD_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .take   (take),
      .item   (item),
      .idle   (core_idle),
      .result (result)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_bus.reg_index)
            bcgl_pkg::REG_AREA_WIDTH:  cfg_in.area_width  = csr_bus.wdata[11:0];
            bcgl_pkg::REG_AREA_HEIGHT: cfg_in.area_height = csr_bus.wdata[11:0];
            bcgl_pkg::REG_BLOCK_SIZE:  cfg_in.block_size  = csr_bus.wdata;
            default: begin
            end
         endcase
      end

      rsp_valid_in = rsp_valid_ff;
      if (take && req_bus.op == bcgl_pkg::OP_BYTE)
         rsp_valid_in = 1'b1;
      else if (rsp_bus.ready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.area_width  <= bcgl_pkg::AREA_WIDTH_RST;
         cfg_ff.area_height <= bcgl_pkg::AREA_HEIGHT_RST;
         cfg_ff.block_size  <= bcgl_pkg::BLOCK_SIZE_RST;
         rsp_valid_ff       <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && req_bus.op == bcgl_pkg::OP_BYTE)
         rsp_data_ff <= result;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.rect_x      = rsp_data_ff.rect_x;
   assign rsp_bus.rect_y      = rsp_data_ff.rect_y;
   assign rsp_bus.rect_width  = rsp_data_ff.rect_width;
   assign rsp_bus.rect_height = rsp_data_ff.rect_height;
   assign rsp_bus.byte_class  = rsp_data_ff.byte_class;

endmodule
